// ===== sv/cpc_pkg.sv =====
package cpc_pkg;

   localparam int NORM_BITS  = 30;
   localparam int SQRT_STEPS = 32;
   localparam int DIV_STEPS  = NORM_BITS + 1;
   localparam logic [15:0] EPS_RESET = 16'd7;
   localparam logic signed [31:0] NORM_ONE = 32'sd1 << NORM_BITS;

   // Fields that ride alongside the square root and divider pipelines.
   typedef struct packed {
      logic        valid;
      logic        contact;
      logic        coin;
      logic [31:0] a_x;
      logic [31:0] a_y;
      logic [30:0] a_radius;
      logic        neg_x;
      logic        neg_y;
      logic [31:0] mag_x;
      logic [31:0] mag_y;
      logic [31:0] rsum;
      logic [30:0] pen;
   } side_type;

endpackage

// ===== sv/cpc_isqrt.sv =====
module cpc_isqrt import cpc_pkg::*; (
   input  logic        clock,
   input  logic        enable,
   input  logic [63:0] radicand,
   output logic [31:0] root
);

   logic [63:0] rem_ff  [SQRT_STEPS];
   logic [63:0] root_ff [SQRT_STEPS];

   // One result bit per stage: the classic remainder and root recurrence.
   for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
      logic [63:0] rem_prev, root_prev, bitv, trial, rem_in, root_in;
      if (k == 0) begin : g_first
         assign rem_prev  = radicand;
         assign root_prev = '0;
      end else begin : g_next
         assign rem_prev  = rem_ff[k-1];
         assign root_prev = root_ff[k-1];
      end
      assign bitv  = 64'd1 << (62 - 2 * k);
      assign trial = root_prev + bitv;
      always_comb begin
         if (rem_prev >= trial) begin
            rem_in  = rem_prev - trial;
            root_in = (root_prev >> 1) + bitv;
         end else begin
            rem_in  = rem_prev;
            root_in = root_prev >> 1;
         end
      end
      always_ff @(posedge clock) begin
         if (enable) begin
            rem_ff[k]  <= rem_in;
            root_ff[k] <= root_in;
         end
      end
   end

   assign root = root_ff[SQRT_STEPS-1][31:0];

endmodule

// ===== sv/cpc_div.sv =====
module cpc_div import cpc_pkg::*; (
   input  logic        clock,
   input  logic        enable,
   input  logic [61:0] numer,
   input  logic [31:0] denom,
   output logic [30:0] quot
);

   logic [31:0] rem_ff  [DIV_STEPS];
   logic [30:0] q_ff    [DIV_STEPS];
   logic [61:0] num_ff  [DIV_STEPS];
   logic [31:0] den_ff  [DIV_STEPS];

   // Restoring division, one quotient bit per stage. The quotient never
   // exceeds 2^30 because the distance is at least each centre offset.
   for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
      logic [31:0] rem_prev, den_prev, rem_in;
      logic [30:0] q_prev, q_in;
      logic [61:0] num_prev;
      logic [32:0] shifted;
      if (k == 0) begin : g_first
         assign rem_prev = {1'b0, numer[61:31]};
         assign q_prev   = '0;
         assign num_prev = numer;
         assign den_prev = denom;
      end else begin : g_next
         assign rem_prev = rem_ff[k-1];
         assign q_prev   = q_ff[k-1];
         assign num_prev = num_ff[k-1];
         assign den_prev = den_ff[k-1];
      end
      assign shifted = {rem_prev, num_prev[DIV_STEPS-1-k]};
      always_comb begin
         if (shifted >= {1'b0, den_prev}) begin
            rem_in = 32'(shifted - {1'b0, den_prev});
            q_in   = {q_prev[29:0], 1'b1};
         end else begin
            rem_in = shifted[31:0];
            q_in   = {q_prev[29:0], 1'b0};
         end
      end
      always_ff @(posedge clock) begin
         if (enable) begin
            rem_ff[k] <= rem_in;
            q_ff[k]   <= q_in;
            num_ff[k] <= num_prev;
            den_ff[k] <= den_prev;
         end
      end
   end

   assign quot = q_ff[DIV_STEPS-1];

endmodule

// ===== sv/circle_pair_contact.sv =====
// Throughput: one item per cycle while the output is not stalled; the 32-stage
// square root and the two 31-stage dividers each retire one item per cycle.
// A stalled result freezes the whole pipeline until it is taken.
// Reset (synchronous, active high) clears all valid bits and sets eps to 7.
module circle_pair_contact import cpc_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write,
   input  logic [15:0]        csr_eps,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [31:0] req_a_x,
   input  logic signed [31:0] req_a_y,
   input  logic [30:0]        req_a_radius,
   input  logic               req_a_static,
   input  logic signed [31:0] req_b_x,
   input  logic signed [31:0] req_b_y,
   input  logic [30:0]        req_b_radius,
   input  logic               req_b_static,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_contact,
   output logic signed [31:0] rsp_normal_x,
   output logic signed [31:0] rsp_normal_y,
   output logic [30:0]        rsp_penetration,
   output logic signed [31:0] rsp_point_x,
   output logic signed [31:0] rsp_point_y
);

   // The whole pipeline advances together unless a finished result is
   // held back by the consumer.
   logic adv;
   assign adv       = !(rsp_valid && rsp_stall);
   assign req_stall = !adv;

   logic [15:0] eps_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         eps_ff <= EPS_RESET;
      end else if (csr_write) begin
         eps_ff <= csr_eps;
      end
   end

   // Stage 0: centre offsets as sign and magnitude, and the radius sum.
   side_type    s0_ff, s0_in;
   logic        both_static_ff;
   logic [32:0] dx, dy;
   always_comb begin
      dx = {req_b_x[31], req_b_x} - {req_a_x[31], req_a_x};
      dy = {req_b_y[31], req_b_y} - {req_a_y[31], req_a_y};
      s0_in          = '0;
      s0_in.valid    = req_valid;
      s0_in.a_x      = req_a_x;
      s0_in.a_y      = req_a_y;
      s0_in.a_radius = req_a_radius;
      s0_in.neg_x    = dx[32];
      s0_in.neg_y    = dy[32];
      s0_in.mag_x    = dx[32] ? 32'(-dx) : dx[31:0];
      s0_in.mag_y    = dy[32] ? 32'(-dy) : dy[31:0];
      s0_in.rsum     = {1'b0, req_a_radius} + {1'b0, req_b_radius};
   end

   // Stage 1: the three squares.
   side_type    s1_ff;
   logic        s1_both_ff;
   logic [63:0] sx_ff, sy_ff, rsq_ff;

   // Stage 2: squared distance and the overlap decision.
   side_type    s2_ff, s2_in;
   logic [63:0] sq_ff;
   logic [64:0] sq_full;
   always_comb begin
      sq_full       = {1'b0, sx_ff} + {1'b0, sy_ff};
      s2_in         = s1_ff;
      s2_in.contact = !s1_both_ff && !sq_full[64] && (sq_full[63:0] < rsq_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_ff.valid <= 1'b0;
         s1_ff.valid <= 1'b0;
         s2_ff.valid <= 1'b0;
      end else if (adv) begin
         s0_ff.valid <= s0_in.valid;
         s1_ff.valid <= s0_ff.valid;
         s2_ff.valid <= s2_in.valid;
      end
      if (adv) begin
         s0_ff[$bits(side_type)-2:0] <= s0_in[$bits(side_type)-2:0];
         both_static_ff <= req_a_static && req_b_static;
         s1_ff[$bits(side_type)-2:0] <= s0_ff[$bits(side_type)-2:0];
         s1_both_ff     <= both_static_ff;
         sx_ff          <= s0_ff.mag_x * s0_ff.mag_x;
         sy_ff          <= s0_ff.mag_y * s0_ff.mag_y;
         rsq_ff         <= s0_ff.rsum * s0_ff.rsum;
         s2_ff[$bits(side_type)-2:0] <= s2_in[$bits(side_type)-2:0];
         sq_ff          <= sq_full[63:0];
      end
   end

   // Square root, with the item's other fields delayed beside it.
   logic [31:0] distance;
   cpc_isqrt u_isqrt (
      .clock    (clock),
      .enable   (adv),
      .radicand (sq_ff),
      .root     (distance)
   );

   side_type sqa_ff [SQRT_STEPS];
   for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqa
      side_type prev;
      if (k == 0) begin : g_first
         assign prev = s2_ff;
      end else begin : g_next
         assign prev = sqa_ff[k-1];
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            sqa_ff[k].valid <= 1'b0;
         end else if (adv) begin
            sqa_ff[k].valid <= prev.valid;
         end
         if (adv) begin
            sqa_ff[k][$bits(side_type)-2:0] <= prev[$bits(side_type)-2:0];
         end
      end
   end

   // Distance stage: coincidence test and the saturated penetration. When
   // there is contact the distance is below the radius sum, so no wrap.
   side_type    sd_ff, sd_in;
   logic [31:0] dist_ff;
   logic [31:0] pen_full;
   always_comb begin
      pen_full   = sqa_ff[SQRT_STEPS-1].rsum - distance;
      sd_in      = sqa_ff[SQRT_STEPS-1];
      sd_in.coin = (distance < {16'd0, eps_ff}) || (distance == '0);
      sd_in.pen  = pen_full[31] ? '1 : pen_full[30:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sd_ff.valid <= 1'b0;
      end else if (adv) begin
         sd_ff.valid <= sd_in.valid;
      end
      if (adv) begin
         sd_ff[$bits(side_type)-2:0] <= sd_in[$bits(side_type)-2:0];
         dist_ff <= distance;
      end
   end

   // Normal components: |d| * 2^30 / dist for each axis.
   logic [30:0] q_x, q_y;
   cpc_div u_div_x (
      .clock  (clock),
      .enable (adv),
      .numer  ({sd_ff.mag_x, 30'd0}),
      .denom  (dist_ff),
      .quot   (q_x)
   );
   cpc_div u_div_y (
      .clock  (clock),
      .enable (adv),
      .numer  ({sd_ff.mag_y, 30'd0}),
      .denom  (dist_ff),
      .quot   (q_y)
   );

   side_type dva_ff [DIV_STEPS];
   for (genvar k = 0; k < DIV_STEPS; k++) begin : g_dva
      side_type prev;
      if (k == 0) begin : g_first
         assign prev = sd_ff;
      end else begin : g_next
         assign prev = dva_ff[k-1];
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            dva_ff[k].valid <= 1'b0;
         end else if (adv) begin
            dva_ff[k].valid <= prev.valid;
         end
         if (adv) begin
            dva_ff[k][$bits(side_type)-2:0] <= prev[$bits(side_type)-2:0];
         end
      end
   end

   // Product stage: normal times A's radius, and the signed normals.
   side_type    sm_ff;
   logic [61:0] prod_x_ff, prod_y_ff;
   logic signed [31:0] nx_ff, ny_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         sm_ff.valid <= 1'b0;
      end else if (adv) begin
         sm_ff.valid <= dva_ff[DIV_STEPS-1].valid;
      end
      if (adv) begin
         sm_ff[$bits(side_type)-2:0] <= dva_ff[DIV_STEPS-1][$bits(side_type)-2:0];
         prod_x_ff <= q_x * dva_ff[DIV_STEPS-1].a_radius;
         prod_y_ff <= q_y * dva_ff[DIV_STEPS-1].a_radius;
         nx_ff <= dva_ff[DIV_STEPS-1].neg_x ? -$signed({1'b0, q_x}) : $signed({1'b0, q_x});
         ny_ff <= dva_ff[DIV_STEPS-1].neg_y ? -$signed({1'b0, q_y}) : $signed({1'b0, q_y});
      end
   end

   // Final stage: contact point with saturation, special cases, output reg.
   logic [30:0] off_x, off_y;
   logic signed [33:0] sum_x, sum_y;
   logic signed [31:0] pt_x, pt_y;
   always_comb begin
      off_x = prod_x_ff[60:30];
      off_y = prod_y_ff[60:30];
      sum_x = $signed({{2{sm_ff.a_x[31]}}, sm_ff.a_x})
            + (sm_ff.neg_x ? -$signed({3'b0, off_x}) : $signed({3'b0, off_x}));
      sum_y = $signed({{2{sm_ff.a_y[31]}}, sm_ff.a_y})
            + (sm_ff.neg_y ? -$signed({3'b0, off_y}) : $signed({3'b0, off_y}));
      if (sum_x[33:31] == 3'b000 || sum_x[33:31] == 3'b111) begin
         pt_x = sum_x[31:0];
      end else begin
         pt_x = sum_x[33] ? 32'sh8000_0000 : 32'sh7fff_ffff;
      end
      if (sum_y[33:31] == 3'b000 || sum_y[33:31] == 3'b111) begin
         pt_y = sum_y[31:0];
      end else begin
         pt_y = sum_y[33] ? 32'sh8000_0000 : 32'sh7fff_ffff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0;
      end else if (adv) begin
         rsp_valid <= sm_ff.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_contact <= sm_ff.contact;
         if (!sm_ff.contact) begin
            rsp_normal_x    <= '0;
            rsp_normal_y    <= '0;
            rsp_penetration <= '0;
            rsp_point_x     <= '0;
            rsp_point_y     <= '0;
         end else if (sm_ff.coin) begin
            rsp_normal_x    <= NORM_ONE;
            rsp_normal_y    <= '0;
            rsp_penetration <= sm_ff.a_radius;
            rsp_point_x     <= sm_ff.a_x;
            rsp_point_y     <= sm_ff.a_y;
         end else begin
            rsp_normal_x    <= nx_ff;
            rsp_normal_y    <= ny_ff;
            rsp_penetration <= sm_ff.pen;
            rsp_point_x     <= pt_x;
            rsp_point_y     <= pt_y;
         end
      end
   end

   a_no_contact_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_contact |->
         rsp_normal_x == 0 && rsp_normal_y == 0 && rsp_penetration == 0
         && rsp_point_x == 0 && rsp_point_y == 0)
      else $error("non-contact result carries nonzero fields");

   a_normal_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_contact |->
         rsp_normal_x <= NORM_ONE && rsp_normal_x >= -NORM_ONE
         && rsp_normal_y <= NORM_ONE && rsp_normal_y >= -NORM_ONE)
      else $error("normal component outside unit range");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid && !sm_ff.valid && !s0_ff.valid)
      else $error("valid bits survive reset");

endmodule
